[hdl/pced_pkg.sv]
// Shared types, constants and helpers for the pin-change edge dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package pced_pkg;

	localparam int NUM_PORTS     = 4;
	localparam int PINS_PER_PORT = 8;
	localparam int PORT_W        = 2;
	localparam int PIN_W         = 3;
	localparam int GPIN_W        = PORT_W + PIN_W;
	localparam int FIFO_DEPTH    = 2;
	localparam int PADDR_W       = 5;
	localparam int PDATA_W       = 64;

	// Item kinds
	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_RESYNC = 1'b1
	} req_t;

	// Per-pin trigger modes
	typedef enum logic [1:0] {
		MODE_LOW  = 2'd0,
		MODE_BOTH = 2'd1,
		MODE_FALL = 2'd2,
		MODE_RISE = 2'd3
	} trig_mode_t;

	// Register indexes (byte address is 8 times the index)
	typedef enum logic [1:0] {
		REG_PIN_MASK   = 2'd0,
		REG_HANDLER_EN = 2'd1,
		REG_TRIGGER    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] pin_mask;
		logic [31:0] handler_enable;
		logic [63:0] trigger_modes;
	} cfg_t;

	// One queued sample with at least one event pending
	typedef struct packed {
		logic [PORT_W-1:0]        port;
		logic [PINS_PER_PORT-1:0] levels;
		logic [PINS_PER_PORT-1:0] evt_mask;
	} evt_entry_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic edge_allowed(input logic [1:0] mode, input logic level);
		logic ok;
		case (mode)
			MODE_BOTH: ok = 1'b1;
			MODE_FALL: ok = ~level;
			MODE_RISE: ok = level;
			default:   ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage
`default_nettype wire

[hdl/pced_if.sv]
// Handshake channel interfaces for sample items and event words.
`timescale 1ns / 1ps
`default_nettype none
interface pced_in_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [pced_pkg::PORT_W-1:0]   port_index;
	logic [7:0]                    pin_levels;
	logic [7:0]                    resync_bits;

	modport source (output valid, req_type, port_index, pin_levels, resync_bits,
		input ready);
	modport sink (input valid, req_type, port_index, pin_levels, resync_bits,
		output ready);
endinterface

interface pced_out_if;
	logic                          valid;
	logic                          ready;
	logic [pced_pkg::GPIN_W-1:0]   pin_number;
	logic                          new_level;
	logic                          last_event;

	modport source (output valid, pin_number, new_level, last_event, input ready);
	modport sink (input valid, pin_number, new_level, last_event, output ready);
endinterface
`default_nettype wire

[hdl/pced_front.sv]
// Front end: takes sample/resync words, finds qualifying edges, keeps stored levels.
`timescale 1ns / 1ps
`default_nettype none
module pced_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	pced_in_if.sink                   in_ch,
	input  wire pced_pkg::cfg_t       cfg,
	input  wire pced_pkg::fifo_stat_t fstat,
	output logic                      push,
	output pced_pkg::evt_entry_t      push_entry
);

	logic [7:0] stored_q [pced_pkg::NUM_PORTS];
	logic       accept;
	logic       port_ok;
	logic [7:0] last_lvl;
	logic [7:0] pm_bits;
	logic [7:0] he_bits;
	logic [15:0] mode_bits;
	logic [7:0] evt_mask;

	assign in_ch.ready = ~fstat.full;
	assign accept  = in_ch.valid & in_ch.ready;
	assign port_ok = 32'(in_ch.port_index) < 32'(pced_pkg::NUM_PORTS);
	assign last_lvl = port_ok ? stored_q[in_ch.port_index] : 8'h00;

	// Slice the port's share of the per-pin registers
	assign pm_bits   = cfg.pin_mask[{in_ch.port_index, 3'b000} +: 8];
	assign he_bits   = cfg.handler_enable[{in_ch.port_index, 3'b000} +: 8];
	assign mode_bits = cfg.trigger_modes[{in_ch.port_index, 4'b0000} +: 16];

	// Per-pin edge qualification
	always_comb begin
		for (int n = 0; n < pced_pkg::PINS_PER_PORT; n++) begin
			evt_mask[n] = pm_bits[n] & he_bits[n]
				& (in_ch.pin_levels[n] != last_lvl[n])
				& pced_pkg::edge_allowed(mode_bits[2*n +: 2], in_ch.pin_levels[n]);
		end
	end

	// Only samples with at least one event go to the queue
	assign push = accept & port_ok & (in_ch.req_type == pced_pkg::REQ_SAMPLE)
		& (evt_mask != 8'h00);
	assign push_entry.port     = in_ch.port_index;
	assign push_entry.levels   = in_ch.pin_levels;
	assign push_entry.evt_mask = evt_mask;

	// Stored level update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < pced_pkg::NUM_PORTS; p++) stored_q[p] <= 8'h00;
		end else if (accept && port_ok) begin
			if (in_ch.req_type == pced_pkg::REQ_RESYNC) begin
				stored_q[in_ch.port_index] <= (last_lvl & ~in_ch.resync_bits)
					| (in_ch.pin_levels & in_ch.resync_bits);
			end else begin
				stored_q[in_ch.port_index] <= in_ch.pin_levels;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/pced_fifo.sv]
// Short queue of pending event sets between front and back.
`timescale 1ns / 1ps
`default_nettype none
module pced_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire pced_pkg::evt_entry_t  push_entry,
	input  wire logic                  pop,
	output pced_pkg::evt_entry_t       head,
	output pced_pkg::fifo_stat_t       fstat
);

	localparam int PTR_W = $clog2(pced_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(pced_pkg::FIFO_DEPTH + 1);

	pced_pkg::evt_entry_t mem_q [pced_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign fstat.full  = count_q == CNT_W'(pced_pkg::FIFO_DEPTH);
	assign fstat.empty = count_q == '0;
	assign do_push = push & ~fstat.full;
	assign do_pop  = pop & ~fstat.empty;
	assign head    = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_W'(pced_pkg::FIFO_DEPTH - 1))
				? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(pced_pkg::FIFO_DEPTH - 1))
				? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[hdl/pced_back.sv]
// Back end: walks event sets by ascending pin, one word per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module pced_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pced_pkg::evt_entry_t  head,
	input  wire pced_pkg::fifo_stat_t  fstat,
	output logic                       pop,
	pced_out_if.source                 out_ch
);

	logic                        busy_q;
	logic [pced_pkg::PORT_W-1:0] port_q;
	logic [7:0]                  lvl_q;
	logic [7:0]                  mask_q;
	logic                        out_valid_q;
	logic [pced_pkg::GPIN_W-1:0] pin_number_q;
	logic                        new_level_q;
	logic                        last_event_q;
	logic                        can_emit;
	logic [7:0]                  pick;
	logic [7:0]                  rem;
	logic [pced_pkg::PIN_W-1:0]  idx;
	logic                        last_one;

	// Lowest pending pin
	assign pick     = mask_q & (~mask_q + 8'd1);
	assign rem      = mask_q & ~pick;
	assign last_one = rem == 8'h00;
	always_comb begin
		idx = '0;
		for (int i = 0; i < pced_pkg::PINS_PER_PORT; i++) begin
			if (pick[i]) idx = idx | pced_pkg::PIN_W'(i);
		end
	end

	assign can_emit = busy_q & (~out_valid_q | out_ch.ready);
	assign pop      = ~fstat.empty & (~busy_q | (can_emit & last_one));

	assign out_ch.valid      = out_valid_q;
	assign out_ch.pin_number = pin_number_q;
	assign out_ch.new_level  = new_level_q;
	assign out_ch.last_event = last_event_q;

	// Work register and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) busy_q <= 1'b1;
			else if (can_emit && last_one) busy_q <= 1'b0;
			if (can_emit) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (pop) begin
			port_q <= head.port;
			lvl_q  <= head.levels;
			mask_q <= head.evt_mask;
		end else if (can_emit) begin
			mask_q <= rem;
		end
		if (can_emit) begin
			pin_number_q <= {port_q, idx};
			new_level_q  <= lvl_q[idx];
			last_event_q <= last_one;
		end
	end

endmodule
`default_nettype wire

[hdl/pin_change_edge_irq_dispatch.sv]
// Top level: APB register file, front end, event queue and back end.
// Event words pass through the queue, the work register and the output register.
// Throughput: one input word per cycle while the 2-entry event queue has room;
// the back end emits one event word per cycle unless out_ch.ready stalls it.
// Reset (arst_n low, async): registers and stored pin levels cleared, queue and
// outputs empty; no clearing pass, the block is usable at the first edge after reset.
`timescale 1ns / 1ps
`default_nettype none
module pin_change_edge_irq_dispatch (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	pced_in_if.sink                            in_ch,
	pced_out_if.source                         out_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pced_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [pced_pkg::PDATA_W-1:0]  pwdata,
	output logic      [pced_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);

	pced_pkg::cfg_t       cfg_q;
	pced_pkg::fifo_stat_t fstat;
	pced_pkg::evt_entry_t push_entry;
	pced_pkg::evt_entry_t head;
	pced_pkg::reg_idx_t   reg_idx;
	logic                 push;
	logic                 pop;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = pced_pkg::reg_idx_t'(paddr[4:3]);
	assign wr_en   = psel & penable & pwrite & pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				pced_pkg::REG_PIN_MASK:   cfg_q.pin_mask       <= pwdata[31:0];
				pced_pkg::REG_HANDLER_EN: cfg_q.handler_enable <= pwdata[31:0];
				pced_pkg::REG_TRIGGER:    cfg_q.trigger_modes  <= pwdata;
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			pced_pkg::REG_PIN_MASK:   prdata = {32'h0, cfg_q.pin_mask};
			pced_pkg::REG_HANDLER_EN: prdata = {32'h0, cfg_q.handler_enable};
			pced_pkg::REG_TRIGGER:    prdata = cfg_q.trigger_modes;
			default:                  prdata = '0;
		endcase
	end

	pced_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg_q),
		.fstat      (fstat),
		.push       (push),
		.push_entry (push_entry)
	);

	pced_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.fstat      (fstat)
	);

	pced_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.fstat  (fstat),
		.pop    (pop),
		.out_ch (out_ch)
	);

	// Queue never pushed while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fstat.full) else $error("event queue overflow");

	// Queue never popped while empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fstat.empty) else $error("event queue underflow");

	// A resync word never produces events
	a_resync_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.req_type == pced_pkg::REQ_RESYNC) |-> !push)
		else $error("resync word queued events");

	// Queued event sets are never empty
	a_nonempty_set: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_entry.evt_mask != 8'h00)) else $error("empty event set queued");

endmodule
`default_nettype wire
